[rtl/hse_pkg.sv]
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the heisenberg site energy block
// spin layout, register codes, reset values and sequencer codes
// ----------------------------------------------------------------------------
package hse_pkg;

  // default lattice geometry
  localparam int HSE_SIDE       = 16;
  localparam int HSE_MAX_LAYERS = 16;

  // fixed point constants
  localparam int ONE_Q12 = 4096;
  localparam int SPIN_W  = 16;

  // one stored spin, x in the lowest bits
  typedef struct packed {
    logic signed [SPIN_W-1:0] z;
    logic signed [SPIN_W-1:0] y;
    logic signed [SPIN_W-1:0] x;
  } spin_t;

  localparam int SPIN_BITS = $bits(spin_t);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_LATTICE_KIND   = 3'd0,
    CFG_COUPLING_MAIN  = 3'd1,
    CFG_COUPLING_INTER = 3'd2,
    CFG_ANISOTROPY     = 3'd3,
    CFG_FIELD          = 3'd4,
    CFG_UPPER_MASK     = 3'd5,
    CFG_LOWER_MASK     = 3'd6,
    CFG_LAYERS         = 3'd7
  } cfg_idx_e;

  // register reset values
  localparam logic        RST_LATTICE_KIND = 1'b0;
  localparam logic [15:0] RST_COUPLING_MAIN = 16'd4096;
  localparam logic [15:0] RST_COUPLING_INTER = 16'd0;
  localparam logic [15:0] RST_ANISOTROPY = 16'd0;
  localparam logic [15:0] RST_FIELD = 16'd0;
  localparam logic [15:0] RST_UPPER_MASK = 16'd0;
  localparam logic [15:0] RST_LOWER_MASK = 16'd0;
  localparam logic [4:0]  RST_LAYERS = 5'd16;

  // input action codes
  typedef enum logic {
    ACT_WRITE   = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_e;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CRD  = 7'b0000010,
    ST_CLAT = 7'b0000100,
    ST_HZ   = 7'b0001000,
    ST_NSEL = 7'b0010000,
    ST_TERM = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  // steps of one pair term on the shared multiplier
  typedef enum logic [3:0] {
    PH_XX    = 4'd0,
    PH_YY    = 4'd1,
    PH_ZZ    = 4'd2,
    PH_SCALE = 4'd3,
    PH_INNER = 4'd4,
    PH_LO    = 4'd5,
    PH_HI    = 4'd6,
    PH_SUB   = 4'd7,
    PH_ACC   = 4'd8
  } term_ph_e;

endpackage

[rtl/heisenberg_site_energy_top.sv]
// ----------------------------------------------------------------------------
// heisenberg_site_energy_top: local site energy of a layered spin lattice
// spin memory plus a sequencer around one shared multiplier
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one word per item: tuser selects a spin write
//   or an energy compute, tdata carries the site and the spin. A write returns
//   nothing. A compute returns one word on the output stream holding the
//   signed Q16.16 energy of the named site.
//   A compute runs over the neighbours in use (4 to 6 simple cubic, 0 to 8
//   body centred), and no new item is taken until its result has gone to
//   the output register. A compute on a layer outside those in use answers
//   zero. Each neighbour is one spin memory read followed by nine steps on
//   the shared 33x18 multiplier and its adders; that loop sets the rate.
//   The user must write the configuration port only while the block is
//   idle; the block itself does not enforce this. Reset clears the
//   sequencer, the output valid and the configuration registers to their
//   defaults; the spin memory is not cleared and each site must be written
//   before it is used. A stalled receiver holds the result in the output
//   register; writes and one more compute may be accepted meanwhile, the
//   compute waiting at its end.
// ----------------------------------------------------------------------------
module heisenberg_site_energy_top
  import hse_pkg::*;
#(
  parameter int SIDE       = HSE_SIDE,
  parameter int MAX_LAYERS = HSE_MAX_LAYERS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: site_i[3:0], site_j[7:4], site_k[11:8], spin_x[27:12],
  //        spin_y[43:28], spin_z[59:44], zero fill[63:60]
  input  logic [63:0] s_axis_tdata,
  // tuser: action[0]
  input  logic        s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: site_energy[31:0]
  output logic [31:0] m_axis_tdata,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IW    = $clog2(SIDE);
  localparam int KW    = $clog2(MAX_LAYERS);
  localparam int DEPTH = SIDE * SIDE * MAX_LAYERS;
  localparam int AW    = $clog2(DEPTH);

  // in-plane index reduced modulo SIDE
  function automatic logic [IW-1:0] wrap_idx(input logic [3:0] v);
    logic [6:0] r;
    r = {3'b000, v};
    for (int s = 0; s < 8; s++) begin
      if (r >= 7'(SIDE)) r = r - 7'(SIDE);
    end
    return IW'(r);
  endfunction

  // memory address of a site
  function automatic logic [AW-1:0] site_addr(input logic [IW-1:0] ii,
                                              input logic [IW-1:0] jj,
                                              input logic [KW-1:0] kk);
    return AW'(kk) * AW'(SIDE * SIDE) + AW'(jj) * AW'(SIDE) + AW'(ii);
  endfunction

  // input fields
  logic [3:0]               in_i, in_j, in_k;
  logic signed [SPIN_W-1:0] in_x, in_y, in_z;
  logic                     in_acc;

  assign in_i   = s_axis_tdata[3:0];
  assign in_j   = s_axis_tdata[7:4];
  assign in_k   = s_axis_tdata[11:8];
  assign in_x   = s_axis_tdata[27:12];
  assign in_y   = s_axis_tdata[43:28];
  assign in_z   = s_axis_tdata[59:44];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // configuration registers
  logic               kind_q;
  logic signed [15:0] jmain_q, jlay_q, aniso_q, field_q;
  logic [15:0]        upper_q, lower_q;
  logic [4:0]         layers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= RST_LATTICE_KIND;
      jmain_q  <= RST_COUPLING_MAIN;
      jlay_q   <= RST_COUPLING_INTER;
      aniso_q  <= RST_ANISOTROPY;
      field_q  <= RST_FIELD;
      upper_q  <= RST_UPPER_MASK;
      lower_q  <= RST_LOWER_MASK;
      layers_q <= RST_LAYERS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LATTICE_KIND:   kind_q   <= cfg_data_i[0];
        CFG_COUPLING_MAIN:  jmain_q  <= cfg_data_i;
        CFG_COUPLING_INTER: jlay_q   <= cfg_data_i;
        CFG_ANISOTROPY:     aniso_q  <= cfg_data_i;
        CFG_FIELD:          field_q  <= cfg_data_i;
        CFG_UPPER_MASK:     upper_q  <= cfg_data_i;
        CFG_LOWER_MASK:     lower_q  <= cfg_data_i;
        CFG_LAYERS:         layers_q <= cfg_data_i[4:0];
      endcase
    end
  end

  // effective layer count, clamped to 1..MAX_LAYERS
  logic [6:0] layers_eff;
  always_comb begin
    if (layers_q == 5'd0) begin
      layers_eff = 7'd1;
    end else if (32'(layers_q) > MAX_LAYERS) begin
      layers_eff = 7'(MAX_LAYERS);
    end else begin
      layers_eff = 7'(layers_q);
    end
  end

  // per item decode of the layer and its neighbours
  logic       in_range, has_below, has_above, is_upper, is_lower;
  logic       in_store;
  logic [7:0] nb_mask;

  assign in_range  = {3'b000, in_k} < layers_eff;
  assign has_below = in_k != 4'd0;
  assign has_above = ({3'b000, in_k} + 7'd1) < layers_eff;
  assign is_upper  = upper_q[in_k];
  assign is_lower  = !is_upper && lower_q[in_k];
  assign in_store  = 32'(in_k) < MAX_LAYERS;
  assign nb_mask   = kind_q ? {4{has_above, has_below}}
                            : {2'b00, has_above, has_below, 4'hF};

  // sequencer and output register
  state_e     state_q, state_d;
  term_ph_e   ph_q, ph_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] rem_q, rem_d;

  // working registers
  logic [IW-1:0]            ci_q, cj_q, im_q, ip_q, jm_q, jp_q;
  logic [KW-1:0]            ck_q, km_q, kp_q;
  logic signed [15:0]       jbelow_q, jabove_q, jc_q;
  spin_t                    c_q;
  logic signed [32:0]       xy_q, zz_q;
  logic signed [48:0]       inner_q;
  logic signed [63:0]       hz26_q, tot_q;
  logic signed [33:0]       acc_q;
  logic [31:0]              out_data_q;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_q;
  logic signed [17:0] omd;

  // spin memory
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SPIN_BITS-1:0] ram_rdata;
  spin_t         rd_spin;

  assign rd_spin = spin_t'(ram_rdata);
  assign omd     = 18'(ONE_Q12) - 18'(aniso_q);

  // lowest remaining neighbour
  logic [2:0]         nsel;
  logic [IW-1:0]      nb_i, nb_j;
  logic [KW-1:0]      nb_k;
  logic signed [15:0] nb_jc;

  always_comb begin
    nsel = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (rem_q[b]) nsel = 3'(b);
    end
  end

  // neighbour coordinates and coupling
  always_comb begin
    nb_i  = ci_q;
    nb_j  = cj_q;
    nb_k  = ck_q;
    nb_jc = jmain_q;
    if (kind_q) begin
      nb_i  = nsel[1] ? ip_q : im_q;
      nb_j  = nsel[2] ? jp_q : jm_q;
      nb_k  = nsel[0] ? kp_q : km_q;
      nb_jc = nsel[0] ? jabove_q : jbelow_q;
    end else begin
      case (nsel)
        3'd0: nb_i = im_q;
        3'd1: nb_i = ip_q;
        3'd2: nb_j = jm_q;
        3'd3: nb_j = jp_q;
        3'd4: begin
          nb_k  = km_q;
          nb_jc = jbelow_q;
        end
        3'd5: begin
          nb_k  = kp_q;
          nb_jc = jabove_q;
        end
        default: ;
      endcase
    end
  end

  // rounded pair term, Q.52 to Q16.16
  logic signed [63:0] rnd;
  assign rnd = tot_q + 64'sh0000_0008_0000_0000;

  // saturated energy
  logic [31:0] sat_energy;
  always_comb begin
    if (!acc_q[33] && (acc_q[32:31] != 2'b00)) begin
      sat_energy = 32'h7FFF_FFFF;
    end else if (acc_q[33] && (acc_q[32:31] != 2'b11)) begin
      sat_energy = 32'h8000_0000;
    end else begin
      sat_energy = acc_q[31:0];
    end
  end

  // next state, memory and multiplier control
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = site_addr(wrap_idx(in_i), wrap_idx(in_j), KW'(in_k));
    ram_raddr   = site_addr(ci_q, cj_q, ck_q);
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ACT_WRITE) begin
            ram_we = in_store;
          end else if (in_range) begin
            rem_d   = nb_mask;
            state_d = ST_CRD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CRD: begin
        ram_re  = 1'b1;
        state_d = ST_CLAT;
      end
      ST_CLAT: begin
        mul_a   = 33'(rd_spin.z);
        mul_b   = 18'(field_q);
        state_d = ST_HZ;
      end
      ST_HZ: begin
        state_d = ST_NSEL;
      end
      ST_NSEL: begin
        if (rem_q == 8'd0) begin
          state_d = ST_DONE;
        end else begin
          ram_re       = 1'b1;
          ram_raddr    = site_addr(nb_i, nb_j, nb_k);
          rem_d[nsel]  = 1'b0;
          ph_d         = PH_XX;
          state_d      = ST_TERM;
        end
      end
      ST_TERM: begin
        unique case (ph_q)
          PH_XX: begin
            mul_a = 33'(rd_spin.x);
            mul_b = 18'(c_q.x);
            ph_d  = PH_YY;
          end
          PH_YY: begin
            mul_a = 33'(rd_spin.y);
            mul_b = 18'(c_q.y);
            ph_d  = PH_ZZ;
          end
          PH_ZZ: begin
            mul_a = 33'(rd_spin.z);
            mul_b = 18'(c_q.z);
            ph_d  = PH_SCALE;
          end
          PH_SCALE: begin
            mul_a = xy_q;
            mul_b = omd;
            ph_d  = PH_INNER;
          end
          PH_INNER: ph_d = PH_LO;
          PH_LO: begin
            mul_a = $signed({9'd0, inner_q[23:0]});
            mul_b = 18'(jc_q);
            ph_d  = PH_HI;
          end
          PH_HI: begin
            mul_a = 33'($signed(inner_q[48:24]));
            mul_b = 18'(jc_q);
            ph_d  = PH_SUB;
          end
          PH_SUB: ph_d = PH_ACC;
          PH_ACC: begin
            ph_d    = PH_XX;
            state_d = ST_NSEL;
          end
          default: ph_d = PH_XX;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_XX;
      rem_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        ci_q     <= wrap_idx(in_i);
        cj_q     <= wrap_idx(in_j);
        im_q     <= (wrap_idx(in_i) == '0) ? IW'(SIDE - 1) : wrap_idx(in_i) - IW'(1);
        ip_q     <= (wrap_idx(in_i) == IW'(SIDE - 1)) ? '0 : wrap_idx(in_i) + IW'(1);
        jm_q     <= (wrap_idx(in_j) == '0) ? IW'(SIDE - 1) : wrap_idx(in_j) - IW'(1);
        jp_q     <= (wrap_idx(in_j) == IW'(SIDE - 1)) ? '0 : wrap_idx(in_j) + IW'(1);
        ck_q     <= KW'(in_k);
        km_q     <= KW'(in_k) - KW'(1);
        kp_q     <= KW'(in_k) + KW'(1);
        jbelow_q <= is_upper ? jlay_q : jmain_q;
        jabove_q <= is_lower ? jlay_q : jmain_q;
        acc_q    <= '0;
      end
      ST_CLAT: c_q <= rd_spin;
      ST_HZ:   hz26_q <= 64'(mul_q) <<< 26;
      ST_NSEL: jc_q <= nb_jc;
      ST_TERM: begin
        case (ph_q)
          PH_YY:    xy_q <= 33'(mul_q);
          PH_ZZ:    xy_q <= xy_q + 33'(mul_q);
          PH_SCALE: zz_q <= 33'(mul_q);
          PH_INNER: inner_q <= 49'(mul_q) + (49'(zz_q) <<< 12);
          PH_HI:    tot_q <= hz26_q - 64'(mul_q);
          PH_SUB:   tot_q <= tot_q - (64'(mul_q) <<< 24);
          PH_ACC:   acc_q <= acc_q + 34'($signed(rnd[63:36]));
          default: ;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= sat_energy;
        end
      end
      default: ;
    endcase
  end

  hse_ram #(
    .WIDTH(SPIN_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({in_z, in_y, in_x}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/hse_ram.sv]
// ----------------------------------------------------------------------------
// hse_ram: generic single write port, single read port memory
// read data is registered and holds until the next read
// ----------------------------------------------------------------------------
module hse_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hse_checker.sv]
// ----------------------------------------------------------------------------
// hse_checker: port level checks of the site energy block
// watches the two streams and is bound to the top level
// ----------------------------------------------------------------------------
module hse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a compute word makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("compute word did not occupy the sequencer");

  // a spin write leaves the input ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("spin write stalled the input");

  // a new result only comes out of a busy sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result word without a compute in flight");

endmodule

bind heisenberg_site_energy_top hse_checker u_hse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[dv/heisenberg_site_energy_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heisenberg_site_energy_top_tb: self-checking bench for the site energy block
// fills the spin lattice around each computed site, predicts every energy word
// in fixed point, and compares it with the output stream under random idling
// ----------------------------------------------------------------------------
module heisenberg_site_energy_top_tb;
  import hse_pkg::*;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     SETTLE_CYCLES  = 100;
  localparam int     STORE_SITES    = HSE_SIDE * HSE_SIDE * HSE_MAX_LAYERS;
  localparam longint ENERGY_MAX     = 64'sd2147483647;
  localparam longint ENERGY_MIN     = -64'sd2147483648;

  // lattice settings as programmed into the block
  typedef struct {
    logic               bcc;
    logic signed [15:0] j_main;
    logic signed [15:0] j_inter;
    logic signed [15:0] delta;
    logic signed [15:0] h;
    logic [15:0]        upper;
    logic [15:0]        lower;
    logic [4:0]         layers;
  } lattice_cfg_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: site_i[3:0], site_j[7:4], site_k[11:8], spin_x[27:12],
  //        spin_y[43:28], spin_z[59:44], zero fill[63:60]
  logic [63:0] s_axis_tdata  = '0;
  // tuser: action[0]
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: site_energy[31:0]
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;

  // predictor state
  lattice_cfg_t       lat_cfg;
  spin_t              spin_mem     [STORE_SITES];
  bit                 site_written [STORE_SITES];
  logic signed [31:0] energy_q[$];
  int                 nb_cnt;
  int                 nb_addr [8];
  longint             nb_cpl  [8];

  int                 item_cnt      = 0;
  int                 fail_cnt      = 0;
  int                 idle_cycles   = 0;
  int                 stall_left    = 0;
  bit                 src_gap_en    = 1'b1;
  bit                 sink_stall_en = 1'b1;
  logic signed [31:0] want_energy;

  heisenberg_site_energy_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int site_addr(int i, int j, int k);
    return (k * HSE_SIDE + j) * HSE_SIDE + i;
  endfunction

  // layer count with out of range values folded back
  function automatic int eff_layers();
    if (lat_cfg.layers == 0) return 1;
    if (lat_cfg.layers > HSE_MAX_LAYERS) return HSE_MAX_LAYERS;
    return lat_cfg.layers;
  endfunction

  function automatic void add_nb(int i, int j, int k, longint cpl);
    nb_addr[nb_cnt] = site_addr(i, j, k);
    nb_cpl[nb_cnt]  = cpl;
    nb_cnt++;
  endfunction

  // neighbour sites of a centre inside the layers in use, with their couplings
  function automatic void find_neighbours(int i, int j, int k);
    int     e, im, ip, jm, jp, d, ni, nj;
    bit     up, lo;
    longint jmain, jint, jb, ja;
    e     = eff_layers();
    im    = (i + HSE_SIDE - 1) % HSE_SIDE;
    ip    = (i + 1) % HSE_SIDE;
    jm    = (j + HSE_SIDE - 1) % HSE_SIDE;
    jp    = (j + 1) % HSE_SIDE;
    jmain = longint'(lat_cfg.j_main);
    jint  = longint'(lat_cfg.j_inter);
    // upper mark beats lower mark on the same layer
    up    = lat_cfg.upper[k];
    lo    = !up && lat_cfg.lower[k];
    jb    = up ? jint : jmain;
    ja    = lo ? jint : jmain;
    nb_cnt = 0;
    if (!lat_cfg.bcc) begin
      add_nb(im, j, k, jmain);
      add_nb(ip, j, k, jmain);
      add_nb(i, jm, k, jmain);
      add_nb(i, jp, k, jmain);
      if (k != 0) add_nb(i, j, k - 1, jb);
      if (k + 1 < e) add_nb(i, j, k + 1, ja);
    end else begin
      for (d = 0; d < 4; d++) begin
        ni = (d % 2 != 0) ? ip : im;
        nj = (d / 2 != 0) ? jp : jm;
        if (k != 0) add_nb(ni, nj, k - 1, jb);
        if (k + 1 < e) add_nb(ni, nj, k + 1, ja);
      end
    end
  endfunction

  // one pair term, exact in Q.52, rounded half up to Q16.16
  function automatic longint pair_energy(spin_t c, spin_t n, longint jc);
    longint omd, xy, zz, inner, hz, total;
    omd   = longint'(ONE_Q12) - longint'(lat_cfg.delta);
    xy    = longint'($signed(c.x)) * longint'($signed(n.x))
          + longint'($signed(c.y)) * longint'($signed(n.y));
    zz    = longint'($signed(c.z)) * longint'($signed(n.z));
    inner = xy * omd + zz * longint'(ONE_Q12);
    hz    = longint'(lat_cfg.h) * longint'($signed(c.z));
    total = -(inner * jc) + (hz <<< 26);
    return (total + (longint'(1) <<< 35)) >>> 36;
  endfunction

  function automatic logic signed [31:0] site_energy_of(int i, int j, int k);
    longint acc;
    spin_t  c;
    int     n;
    acc = 0;
    if (k >= eff_layers()) return '0;
    find_neighbours(i, j, k);
    c = spin_mem[site_addr(i, j, k)];
    for (n = 0; n < nb_cnt; n++) acc += pair_energy(c, spin_mem[nb_addr[n]], nb_cpl[n]);
    if (acc > ENERGY_MAX) acc = ENERGY_MAX;
    if (acc < ENERGY_MIN) acc = ENERGY_MIN;
    return acc[31:0];
  endfunction

  function automatic void cfg_plain();
    lat_cfg.bcc     = RST_LATTICE_KIND;
    lat_cfg.j_main  = RST_COUPLING_MAIN;
    lat_cfg.j_inter = RST_COUPLING_INTER;
    lat_cfg.delta   = RST_ANISOTROPY;
    lat_cfg.h       = RST_FIELD;
    lat_cfg.upper   = RST_UPPER_MASK;
    lat_cfg.lower   = RST_LOWER_MASK;
    lat_cfg.layers  = RST_LAYERS;
  endfunction

  // ---------------------------------------------------------------------------
  // random values
  // ---------------------------------------------------------------------------

  function automatic spin_t mk_spin(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    spin_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    return s;
  endfunction

  // mostly unit range, sometimes the full 16 bits
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'h4000;
      2:       return 16'hc000;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic spin_t rand_spin();
    return mk_spin(rand_comp(), rand_comp(), rand_comp());
  endfunction

  function automatic logic [15:0] pick_q12();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'h1000;
      4:       return 16'($urandom);
      default: return 16'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // send one word, then predict its effect at acceptance
  task automatic send_item(action_e act, int i, int j, int k, spin_t s);
    int gap;
    if (src_gap_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'h0, s.z, s.y, s.x, k[3:0], j[3:0], i[3:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    item_cnt++;
    if (act == ACT_WRITE) begin
      spin_mem[site_addr(i, j, k)]     = s;
      site_written[site_addr(i, j, k)] = 1'b1;
    end else begin
      energy_q.push_back(site_energy_of(i, j, k));
    end
  endtask

  // write any site the energy would read that was never written, then compute
  task automatic compute_site(int i, int j, int k);
    int a [9];
    int cnt, n;
    if (k < eff_layers()) begin
      find_neighbours(i, j, k);
      a[0] = site_addr(i, j, k);
      for (n = 0; n < nb_cnt; n++) a[n + 1] = nb_addr[n];
      cnt = nb_cnt + 1;
      for (n = 0; n < cnt; n++) begin
        if (!site_written[a[n]])
          send_item(ACT_WRITE, a[n] % HSE_SIDE, (a[n] / HSE_SIDE) % HSE_SIDE,
                    a[n] / (HSE_SIDE * HSE_SIDE), rand_spin());
      end
    end
    send_item(ACT_COMPUTE, i, j, k, rand_spin());
  endtask

  // drain all results and let a trailing write or compute finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // program every register from lat_cfg, block idle
  task automatic apply_cfg();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LATTICE_KIND;
    cfg_data_i <= {15'd0, lat_cfg.bcc};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COUPLING_MAIN;
    cfg_data_i <= lat_cfg.j_main;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COUPLING_INTER;
    cfg_data_i <= lat_cfg.j_inter;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ANISOTROPY;
    cfg_data_i <= lat_cfg.delta;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FIELD;
    cfg_data_i <= lat_cfg.h;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UPPER_MASK;
    cfg_data_i <= lat_cfg.upper;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LOWER_MASK;
    cfg_data_i <= lat_cfg.lower;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LAYERS;
    cfg_data_i <= {11'd0, lat_cfg.layers};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings, extreme spins on a cross that wraps around the corner
  task automatic test_reset_defaults();
    send_item(ACT_WRITE, 0, 0, 0, mk_spin(16'h8000, 16'h7fff, 16'h4000));
    send_item(ACT_WRITE, 15, 0, 0, mk_spin(16'hc000, 16'hc000, 16'hc000));
    send_item(ACT_WRITE, 1, 0, 0, mk_spin(16'h4000, 16'h4000, 16'h4000));
    send_item(ACT_WRITE, 0, 15, 0, mk_spin(16'h7fff, 16'h8000, 16'h0000));
    send_item(ACT_WRITE, 0, 1, 0, mk_spin(16'h0000, 16'h0000, 16'hc000));
    send_item(ACT_WRITE, 0, 0, 1, mk_spin(16'h4000, 16'hffff, 16'h8000));
    compute_site(0, 0, 0);
  endtask

  // top layer at the far corner, only a neighbour below
  task automatic test_top_corner();
    compute_site(15, 15, 15);
  endtask

  // layer count of zero, one and above the store, compute outside the layers
  task automatic test_layer_count();
    wait_idle();
    cfg_plain();
    lat_cfg.layers = 5'd0;
    lat_cfg.upper  = 16'hffff;
    lat_cfg.j_inter = 16'h2000;
    apply_cfg();
    compute_site(0, 0, 0);
    send_item(ACT_COMPUTE, 0, 0, 5, rand_spin());
    wait_idle();
    lat_cfg.layers = 5'd31;
    apply_cfg();
    compute_site(15, 15, 15);
    wait_idle();
    lat_cfg.layers = 5'd17;
    apply_cfg();
    compute_site(15, 15, 15);
    wait_idle();
    // body centred on a single layer has no neighbour at all
    lat_cfg.layers = 5'd1;
    lat_cfg.bcc    = 1'b1;
    apply_cfg();
    compute_site(0, 0, 0);
  endtask

  // both marks on one layer, then the lower mark alone, then the upper mark
  task automatic test_layer_masks();
    wait_idle();
    cfg_plain();
    lat_cfg.layers  = 5'd2;
    lat_cfg.j_main  = 16'h2000;
    lat_cfg.j_inter = 16'h8000;
    lat_cfg.upper   = 16'h0001;
    lat_cfg.lower   = 16'h0001;
    apply_cfg();
    compute_site(0, 0, 0);
    wait_idle();
    lat_cfg.upper = 16'h0000;
    apply_cfg();
    compute_site(0, 0, 0);
    wait_idle();
    lat_cfg.layers = 5'd16;
    lat_cfg.upper  = 16'h8000;
    apply_cfg();
    compute_site(15, 15, 15);
  endtask

  // coupling, anisotropy and field at their limits
  task automatic test_coupling_extremes();
    wait_idle();
    cfg_plain();
    lat_cfg.layers = 5'd2;
    lat_cfg.j_main = 16'h8000;
    lat_cfg.delta  = 16'h8000;
    lat_cfg.h      = 16'h7fff;
    apply_cfg();
    compute_site(0, 0, 0);
    wait_idle();
    lat_cfg.j_main = 16'h7fff;
    lat_cfg.delta  = 16'h7fff;
    lat_cfg.h      = 16'h8000;
    apply_cfg();
    compute_site(0, 0, 0);
    wait_idle();
    lat_cfg.j_main = 16'h0000;
    lat_cfg.h      = 16'h7fff;
    apply_cfg();
    compute_site(0, 0, 0);
  endtask

  // diagonal neighbours in the layer below, all pairs interlayer
  task automatic test_body_centred();
    wait_idle();
    cfg_plain();
    lat_cfg.bcc     = 1'b1;
    lat_cfg.j_inter = 16'hf000;
    lat_cfg.upper   = 16'hffff;
    apply_cfg();
    compute_site(15, 15, 15);
  endtask

  // one phase of random settings and random traffic
  task automatic run_random_phase(int n_items, bit idling);
    int stop_at, e, i, j, r;
    wait_idle();
    lat_cfg.bcc     = 1'($urandom_range(0, 1));
    lat_cfg.j_main  = pick_q12();
    lat_cfg.j_inter = pick_q12();
    lat_cfg.delta   = pick_q12();
    lat_cfg.h       = pick_q12();
    lat_cfg.upper   = pick_mask();
    lat_cfg.lower   = pick_mask();
    case ($urandom_range(0, 9))
      0:       lat_cfg.layers = 5'd0;
      1:       lat_cfg.layers = 5'd1;
      2:       lat_cfg.layers = 5'd16;
      3:       lat_cfg.layers = 5'd17;
      4:       lat_cfg.layers = 5'd31;
      5:       lat_cfg.layers = 5'($urandom_range(0, 31));
      default: lat_cfg.layers = 5'($urandom_range(2, 4));
    endcase
    apply_cfg();
    src_gap_en    = idling && $urandom_range(0, 2) != 0;
    sink_stall_en = idling && $urandom_range(0, 2) != 0;
    e       = eff_layers();
    stop_at = item_cnt + n_items;
    while (item_cnt < stop_at) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        // stray write anywhere in the store
        send_item(ACT_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), rand_spin());
      end else if (r == 1 && e < HSE_MAX_LAYERS) begin
        send_item(ACT_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(e, 15), rand_spin());
      end else begin
        // sites near the wrap half the time so the lattice fills up and reuses
        i = $urandom_range(0, 1) ? (14 + $urandom_range(0, 4)) % 16 : $urandom_range(0, 15);
        j = $urandom_range(0, 1) ? (14 + $urandom_range(0, 4)) % 16 : $urandom_range(0, 15);
        r = $urandom_range(0, e - 1);
        if ($urandom_range(0, 3) == 0) send_item(ACT_WRITE, i, j, r, rand_spin());
        compute_site(i, j, r);
      end
    end
  endtask

  task automatic test_random_mix();
    while (item_cnt < 1250) run_random_phase($urandom_range(40, 120), 1'b1);
  endtask

  task automatic test_random_no_idle();
    run_random_phase(150, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    cfg_plain();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_top_corner();
    test_layer_count();
    test_layer_masks();
    test_coupling_extremes();
    test_body_centred();
    test_random_mix();
    test_random_no_idle();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver with random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each output word with the oldest predicted energy
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (energy_q.size() == 0) begin
        $error("site_energy word %0d arrived with none predicted", $signed(m_axis_tdata));
        fail_cnt++;
      end else begin
        want_energy = energy_q.pop_front();
        if (m_axis_tdata !== want_energy) begin
          $error("site_energy mismatch: expected %0d, actual %0d",
                 want_energy, $signed(m_axis_tdata));
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

[files.f]
rtl/hse_pkg.sv
rtl/hse_ram.sv
rtl/heisenberg_site_energy_top.sv
rtl/hse_checker.sv
dv/heisenberg_site_energy_top_tb.sv
